// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertions with reset disable; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication: cond |-> expr
`define ASSERT_IMPL(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (expr)) \
        else $error("%m: assertion failed");
// Next-cycle implication: cond |=> expr
`define ASSERT_NEXT(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
        else $error("%m: assertion failed");
`else
`define ASSERT_IMPL(label, clk, rstn, cond, expr)
`define ASSERT_NEXT(label, clk, rstn, cond, expr)
`endif

`endif

// ----- hw/rtl/qps_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qps_pkg
// Shared constants, event codes and control/status types for the encoder
// position and speed block.
// ---------------------------------------------------------------------------
package qps_pkg;

    // Default width of the hardware encoder counter
    localparam int COUNTER_BITS_DEF = 16;

    // Field widths
    localparam int CPR_W   = 20;
    localparam int CAP_W   = 16;
    localparam int WRAP_W  = 16;
    localparam int POS_W   = 21;
    localparam int SPEED_W = 18;

    // Register reset and limits
    localparam logic [CPR_W-1:0] CPR_RESET = 20'd2048;
    localparam int SPEED_MAX = 131071;
    localparam logic [CAP_W-1:0] CAP_FULL_MASK = 16'hFFFF;

    // Event codes
    localparam logic [1:0] MODE_OVERFLOW  = 2'd0;
    localparam logic [1:0] MODE_UNDERFLOW = 2'd1;
    localparam logic [1:0] MODE_POS_CAP   = 2'd2;
    localparam logic [1:0] MODE_SPEED_CAP = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;    // input item taken this cycle
        logic load;      // load divider from the position capture
        logic step;      // one remainder iteration
        logic out_load;  // latch results into the output register
    } qps_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic fire;      // current input item completes both measurements
    } qps_sts_t;

endpackage

// ----- hw/rtl/qps_datapath.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qps_datapath
// Event state, capture registers, bit-serial remainder unit, speed
// difference logic and the output register.
// ---------------------------------------------------------------------------
module qps_datapath #(
    parameter int COUNTER_BITS = qps_pkg::COUNTER_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [qps_pkg::CPR_W-1:0]          cfg_wr_data,
    input  logic                               cfg_wr_en,
    input  logic [1:0]                         s_mode,
    input  logic [qps_pkg::CAP_W-1:0]          s_capture_value,
    input  logic                               s_direction_up,
    input  qps_pkg::qps_cmd_t                  cmd,
    output qps_pkg::qps_sts_t                  sts,
    output logic signed [qps_pkg::POS_W-1:0]   m_position,
    output logic signed [qps_pkg::SPEED_W-1:0] m_speed_counts,
    output logic                               m_oscillation
);

    localparam int CPR_W  = qps_pkg::CPR_W;
    localparam int CAP_W  = qps_pkg::CAP_W;
    localparam int WRAP_W = qps_pkg::WRAP_W;
    localparam int MAG_W  = WRAP_W + COUNTER_BITS;
    localparam int SPAN_W = (COUNTER_BITS > CAP_W) ? COUNTER_BITS : CAP_W;
    localparam int D_W    = SPAN_W + 2;
    localparam logic [CAP_W-1:0] CAP_MASK = (COUNTER_BITS >= CAP_W) ?
        qps_pkg::CAP_FULL_MASK : CAP_W'((64'd1 << COUNTER_BITS) - 64'd1);
    localparam logic signed [D_W-1:0] SAT_HI = D_W'(qps_pkg::SPEED_MAX);
    localparam logic signed [D_W-1:0] SAT_LO = -SAT_HI;
    localparam logic signed [D_W-1:0] SPAN   = D_W'(1) << COUNTER_BITS;

    // Configuration register
    logic [CPR_W-1:0] cpr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpr_reg <= qps_pkg::CPR_RESET;
        end else if (cfg_wr_en) begin
            cpr_reg <= cfg_wr_data;
        end
    end

    // Event state
    logic [WRAP_W-1:0] wrap_count_reg, wrap_count_next;
    logic [WRAP_W-1:0] pos_wrap_snapshot_reg, pos_wrap_snapshot_next;
    logic [CAP_W-1:0]  pos_capture_reg, pos_capture_next;
    logic              pos_taken_reg, pos_taken_next;
    logic              speed_phase_reg, speed_phase_next;
    logic              speed_done_reg, speed_done_next;
    logic [CAP_W-1:0]  speed_first_reg, speed_first_next;
    logic [CAP_W-1:0]  speed_second_reg, speed_second_next;
    logic [WRAP_W-1:0] wrap_at_first_reg, wrap_at_first_next;
    logic [WRAP_W-1:0] wrap_at_second_reg, wrap_at_second_next;
    logic              up_reg, up_next;
    logic [CAP_W-1:0]  cap_m;
    logic              fire;

    assign cap_m = s_capture_value & CAP_MASK;

    // Item completes the pair of measurements
    assign fire = ((s_mode == qps_pkg::MODE_POS_CAP) && !pos_taken_reg && speed_done_reg) ||
                  ((s_mode == qps_pkg::MODE_SPEED_CAP) && !speed_done_reg &&
                   speed_phase_reg && pos_taken_reg);
    assign sts.fire = fire;

    always_comb begin
        wrap_count_next        = wrap_count_reg;
        pos_wrap_snapshot_next = pos_wrap_snapshot_reg;
        pos_capture_next       = pos_capture_reg;
        pos_taken_next         = pos_taken_reg;
        speed_phase_next       = speed_phase_reg;
        speed_done_next        = speed_done_reg;
        speed_first_next       = speed_first_reg;
        speed_second_next      = speed_second_reg;
        wrap_at_first_next     = wrap_at_first_reg;
        wrap_at_second_next    = wrap_at_second_reg;
        up_next                = up_reg;
        if (cmd.accept) begin
            up_next = s_direction_up;
            case (s_mode)
                qps_pkg::MODE_OVERFLOW: begin
                    wrap_count_next = wrap_count_reg + 16'd1;
                end
                qps_pkg::MODE_UNDERFLOW: begin
                    wrap_count_next = wrap_count_reg - 16'd1;
                end
                qps_pkg::MODE_POS_CAP: begin
                    if (!pos_taken_reg) begin
                        pos_capture_next       = cap_m;
                        pos_wrap_snapshot_next = wrap_count_reg;
                        pos_taken_next         = 1'b1;
                    end
                end
                default: begin
                    if (!speed_done_reg) begin
                        if (!speed_phase_reg) begin
                            speed_first_next   = cap_m;
                            wrap_at_first_next = wrap_count_reg;
                            speed_phase_next   = 1'b1;
                        end else begin
                            speed_second_next   = cap_m;
                            wrap_at_second_next = wrap_count_reg;
                            speed_phase_next    = 1'b0;
                            speed_done_next     = 1'b1;
                        end
                    end
                end
            endcase
            // Re-arm once the result is under way
            if (fire) begin
                pos_taken_next  = 1'b0;
                speed_done_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wrap_count_reg        <= '0;
            pos_wrap_snapshot_reg <= '0;
            pos_capture_reg       <= '0;
            pos_taken_reg         <= 1'b0;
            speed_phase_reg       <= 1'b0;
            speed_done_reg        <= 1'b0;
            speed_first_reg       <= '0;
            speed_second_reg      <= '0;
            wrap_at_first_reg     <= '0;
            wrap_at_second_reg    <= '0;
            up_reg                <= 1'b0;
        end else begin
            wrap_count_reg        <= wrap_count_next;
            pos_wrap_snapshot_reg <= pos_wrap_snapshot_next;
            pos_capture_reg       <= pos_capture_next;
            pos_taken_reg         <= pos_taken_next;
            speed_phase_reg       <= speed_phase_next;
            speed_done_reg        <= speed_done_next;
            speed_first_reg       <= speed_first_next;
            speed_second_reg      <= speed_second_next;
            wrap_at_first_reg     <= wrap_at_first_next;
            wrap_at_second_reg    <= wrap_at_second_next;
            up_reg                <= up_next;
        end
    end

    // Extended count: wrap snapshot on top of the capture
    logic [MAG_W-1:0] cap_wide;
    logic [MAG_W-1:0] ext;
    logic [MAG_W-1:0] ext_mag;

    assign cap_wide = {{COUNTER_BITS{1'b0}}, pos_capture_reg};
    assign ext      = {pos_wrap_snapshot_reg, cap_wide[COUNTER_BITS-1:0]};
    assign ext_mag  = ext[MAG_W-1] ? ((~ext) + {{(MAG_W-1){1'b0}}, 1'b1}) : ext;

    // Restoring remainder, one dividend bit per step
    logic [MAG_W-1:0] dvd_reg, dvd_next;
    logic [CPR_W-1:0] rem_reg, rem_next;
    logic             neg_reg, neg_next;
    logic [CPR_W:0]   trial;
    logic [CPR_W:0]   trial_sub;

    assign trial     = {rem_reg, dvd_reg[MAG_W-1]};
    assign trial_sub = trial - {1'b0, cpr_reg};

    always_comb begin
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        neg_next = neg_reg;
        if (cmd.load) begin
            dvd_next = ext_mag;
            rem_next = '0;
            neg_next = ext[MAG_W-1];
        end else if (cmd.step) begin
            dvd_next = {dvd_reg[MAG_W-2:0], 1'b0};
            rem_next = (trial >= {1'b0, cpr_reg}) ? trial_sub[CPR_W-1:0] : trial[CPR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    // Signed position from the remainder
    logic [qps_pkg::POS_W-1:0] pos_abs;
    logic [qps_pkg::POS_W-1:0] pos_val;

    assign pos_abs = {1'b0, rem_reg};
    always_comb begin
        if (cpr_reg == '0) begin
            pos_val = '0;
        end else if (neg_reg) begin
            pos_val = '0 - pos_abs;
        end else begin
            pos_val = pos_abs;
        end
    end

    // Speed difference with single-wrap correction
    logic signed [D_W-1:0] old_s, new_s, d, d_sat;
    logic                  osc;
    logic signed [WRAP_W-1:0] w1, w2;

    assign old_s = $signed({{(D_W-CAP_W){1'b0}}, speed_first_reg});
    assign new_s = $signed({{(D_W-CAP_W){1'b0}}, speed_second_reg});
    assign w1    = $signed(wrap_at_first_reg);
    assign w2    = $signed(wrap_at_second_reg);

    always_comb begin
        if (w2 == w1) begin
            d   = new_s - old_s;
            osc = ((d <= 0) && up_reg) || ((d >= 0) && !up_reg);
        end else if (w2 > w1) begin
            d   = new_s + SPAN - old_s;
            osc = (d >= 0) && !up_reg;
        end else begin
            d   = new_s - old_s - SPAN;
            osc = (d <= 0) && up_reg;
        end
        if (d > SAT_HI) begin
            d_sat = SAT_HI;
        end else if (d < SAT_LO) begin
            d_sat = SAT_LO;
        end else begin
            d_sat = d;
        end
    end

    // Output register
    logic signed [qps_pkg::POS_W-1:0]   position_reg;
    logic signed [qps_pkg::SPEED_W-1:0] speed_reg;
    logic                               osc_reg;

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            position_reg <= $signed(pos_val);
            speed_reg    <= d_sat[qps_pkg::SPEED_W-1:0];
            osc_reg      <= osc;
        end
    end

    assign m_position     = position_reg;
    assign m_speed_counts = speed_reg;
    assign m_oscillation  = osc_reg;

endmodule

// ----- hw/rtl/qps_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qps_ctrl
// Sequencer: item acceptance, remainder iteration count and result
// hand-off to the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module qps_ctrl #(
    parameter int COUNTER_BITS = qps_pkg::COUNTER_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  qps_pkg::qps_sts_t sts,
    output qps_pkg::qps_cmd_t cmd
);

    localparam int MAG_W = qps_pkg::WRAP_W + COUNTER_BITS;
    localparam int CNT_W = $clog2(MAG_W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic             accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd.accept   = accept;
        cmd.load     = 1'b0;
        cmd.step     = 1'b0;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept && sts.fire) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                cnt_next   = CNT_W'(MAG_W - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid flag
    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Checks
    `ASSERT_NEXT(a_fire_starts, aclk, aresetn, accept && sts.fire, state_reg == ST_LOAD)
    `ASSERT_NEXT(a_load_count, aclk, aresetn, state_reg == ST_LOAD,
                 (state_reg == ST_DIV) && (cnt_reg == CNT_W'(MAG_W - 1)))
    `ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_valid_reg && !m_ready, m_valid_reg)
    `ASSERT_IMPL(a_no_overwrite, aclk, aresetn, cmd.out_load, !m_valid_reg || m_ready)

endmodule

// ----- hw/rtl/quadrature_position_speed.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quadrature_position_speed
// Encoder event tracker producing shaft position and speed measurements.
// ---------------------------------------------------------------------------
// Usage:
//   s_* channel: one encoder event per item (overflow, underflow, position
//   capture, speed capture) with valid/ready handshake.
//   m_* channel: one result (position, speed_counts, oscillation) after the
//   item that completes a position capture and a speed capture pair.
//   cfg_wr_en / cfg_wr_data: counts per revolution, written while idle.
// Timing:
//   Items that give no result are taken one per cycle while idle.
//   An item that completes a measurement starts the remainder loop: a load
//   state, 16 + COUNTER_BITS iterations, then a hand-off state that loads the
//   output register. No item is taken until the controller is idle again.
// Reset: all capture state clears, counts per revolution returns to 2048,
//   no result is pending.
// Stall: the result waits in the output register; items that give no result
//   are still taken, and a new result waits in the controller until the
//   output register is free.
// ---------------------------------------------------------------------------
module quadrature_position_speed #(
    parameter int COUNTER_BITS = qps_pkg::COUNTER_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [qps_pkg::CPR_W-1:0]          cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_mode,
    input  logic [qps_pkg::CAP_W-1:0]          s_capture_value,
    input  logic                               s_direction_up,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [qps_pkg::POS_W-1:0]   m_position,
    output logic signed [qps_pkg::SPEED_W-1:0] m_speed_counts,
    output logic                               m_oscillation
);

    qps_pkg::qps_cmd_t cmd;
    qps_pkg::qps_sts_t sts;

    // Sequencer
    qps_ctrl #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath
    qps_datapath #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_data     (cfg_wr_data),
        .cfg_wr_en       (cfg_wr_en),
        .s_mode          (s_mode),
        .s_capture_value (s_capture_value),
        .s_direction_up  (s_direction_up),
        .cmd             (cmd),
        .sts             (sts),
        .m_position      (m_position),
        .m_speed_counts  (m_speed_counts),
        .m_oscillation   (m_oscillation)
    );

endmodule
